[src/sdfe_pkg.sv]
package sdfe_pkg;

   localparam int MAX_OBJECTS      = 32;
   localparam int WORDS_PER_OBJECT = 16;
   localparam int OBJ_W            = $clog2(MAX_OBJECTS);
   localparam int OBJ_CNT_W        = $clog2(MAX_OBJECTS + 1);
   localparam int WORD_W           = $clog2(WORDS_PER_OBJECT);
   localparam int TBL_DEPTH        = MAX_OBJECTS * WORDS_PER_OBJECT;
   localparam int TBL_AW           = $clog2(TBL_DEPTH);
   localparam int CFG_W            = 6;
   localparam int REQ_W            = 144;
   localparam int RSP_W            = 32;
   localparam int PC_W             = 7;
   localparam int RF_AW            = 4;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic signed [31:0] Q_ONE    = 32'sd65536;
   localparam logic signed [31:0] Q_HALF   = 32'sd32768;
   localparam logic signed [31:0] Q_RSQRT2 = 32'sd46341;
   localparam logic signed [31:0] Q_MAX    = 32'sh7fffffff;
   localparam logic signed [31:0] Q_MIN    = 32'sh80000000;

   typedef enum logic [4:0] {
      OP_ADD, OP_SUB, OP_MAX, OP_MIN, OP_NEG, OP_ABS, OP_MOVB,
      OP_MUL, OP_SQ0, OP_SQA, OP_SQRT, OP_LDTW, OP_CHK, OP_JMP,
      OP_JTYPE, OP_JOP, OP_NXT, OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_EX, S_MUL, S_SQ, S_SQRT, S_OUT
   } state_type;

   // scratch registers
   localparam logic [RF_AW-1:0] R_DIST = 4'd0;
   localparam logic [RF_AW-1:0] R_M0   = 4'd1;
   localparam logic [RF_AW-1:0] R_M1   = 4'd2;
   localparam logic [RF_AW-1:0] R_M2   = 4'd3;
   localparam logic [RF_AW-1:0] R_A    = 4'd4;
   localparam logic [RF_AW-1:0] R_B    = 4'd5;
   localparam logic [RF_AW-1:0] R_C    = 4'd6;
   localparam logic [RF_AW-1:0] R_D    = 4'd7;
   localparam logic [RF_AW-1:0] R_E    = 4'd8;
   localparam logic [RF_AW-1:0] R_F    = 4'd9;
   localparam logic [RF_AW-1:0] R_BL   = 4'd10;
   localparam logic [RF_AW-1:0] R_OD   = 4'd11;

   // constant operands
   localparam logic [3:0] K_ZERO = 4'd0;
   localparam logic [3:0] K_HALF = 4'd1;
   localparam logic [3:0] K_ONE  = 4'd2;
   localparam logic [3:0] K_RSQ2 = 4'd3;
   localparam logic [3:0] K_PX   = 4'd4;
   localparam logic [3:0] K_PY   = 4'd5;
   localparam logic [3:0] K_PZ   = 4'd6;

   localparam logic [3:0] W_SCALE = 4'd12;
   localparam logic [3:0] W_BLEND = 4'd13;
   localparam logic [3:0] W_TYPE  = 4'd14;

   localparam logic SRC_REG = 1'b0;
   localparam logic SRC_TBL = 1'b1;
   localparam logic SRC_CON = 1'b1;

   localparam logic [PC_W-1:0] L_OBJ   = 7'd1;
   localparam logic [PC_W-1:0] L_JT    = 7'd23;
   localparam logic [PC_W-1:0] L_SPH   = 7'd27;
   localparam logic [PC_W-1:0] L_BOX   = 7'd33;
   localparam logic [PC_W-1:0] L_PIPE  = 7'd53;
   localparam logic [PC_W-1:0] L_DON   = 7'd61;
   localparam logic [PC_W-1:0] L_SCALE = 7'd68;
   localparam logic [PC_W-1:0] L_JO    = 7'd70;
   localparam logic [PC_W-1:0] L_DR    = 7'd78;
   localparam logic [PC_W-1:0] L_DC    = 7'd80;
   localparam logic [PC_W-1:0] L_ZR    = 7'd82;
   localparam logic [PC_W-1:0] L_UR    = 7'd84;
   localparam logic [PC_W-1:0] L_UC    = 7'd95;
   localparam logic [PC_W-1:0] L_IR    = 7'd101;
   localparam logic [PC_W-1:0] L_IC    = 7'd113;
   localparam logic [PC_W-1:0] L_NEXT  = 7'd119;
   localparam logic [PC_W-1:0] L_DONE  = 7'd120;

   typedef struct packed {
      op_type           op;
      logic [RF_AW-1:0] dst;
      logic             xt;
      logic [3:0]       xi;
      logic             yc;
      logic [3:0]       yi;
      logic [PC_W-1:0]  tgt;
   } uins_type;

   function automatic logic signed [31:0] sat_w(input logic signed [48:0] v);
      if (v > 49'(Q_MAX)) return Q_MAX;
      if (v < 49'(Q_MIN)) return Q_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] qround(input logic signed [65:0] p);
      logic signed [65:0] v;
      v = p + 66'sd32768;
      return sat_w($signed(v[64:16]));
   endfunction

   function automatic uins_type ui(input op_type op, input logic [3:0] d, input logic xt,
                                   input logic [3:0] xi, input logic yc,
                                   input logic [3:0] yi, input logic [PC_W-1:0] t);
      uins_type u;
      u.op = op; u.dst = d; u.xt = xt; u.xi = xi; u.yc = yc; u.yi = yi; u.tgt = t;
      return u;
   endfunction

   function automatic uins_type rr(input op_type op, input logic [3:0] d,
                                   input logic [3:0] x, input logic [3:0] y);
      return ui(op, d, SRC_REG, x, SRC_REG, y, L_OBJ);
   endfunction

   function automatic uins_type rk(input op_type op, input logic [3:0] d,
                                   input logic [3:0] x, input logic [3:0] k);
      return ui(op, d, SRC_REG, x, SRC_CON, k, L_OBJ);
   endfunction

   function automatic uins_type tk(input op_type op, input logic [3:0] d,
                                   input logic [3:0] w, input logic [3:0] k);
      return ui(op, d, SRC_TBL, w, SRC_CON, k, L_OBJ);
   endfunction

   function automatic uins_type tr(input op_type op, input logic [3:0] d,
                                   input logic [3:0] w, input logic [3:0] y);
      return ui(op, d, SRC_TBL, w, SRC_REG, y, L_OBJ);
   endfunction

   function automatic uins_type jp(input op_type op, input logic [PC_W-1:0] t);
      return ui(op, R_DIST, SRC_REG, R_DIST, SRC_REG, R_DIST, t);
   endfunction

   function automatic uins_type rom_fetch(input logic [PC_W-1:0] pc);
      uins_type u;
      unique case (pc)
         7'd0:   u = rk(OP_MOVB, R_DIST, R_DIST, K_PY);
         7'd1:   u = jp(OP_CHK, L_DONE);
         7'd2:   u = tk(OP_MUL, R_M0, 4'd0, K_PX);
         7'd3:   u = tk(OP_MUL, R_A, 4'd1, K_PY);
         7'd4:   u = rr(OP_ADD, R_M0, R_M0, R_A);
         7'd5:   u = tk(OP_MUL, R_A, 4'd2, K_PZ);
         7'd6:   u = rr(OP_ADD, R_M0, R_M0, R_A);
         7'd7:   u = tr(OP_ADD, R_M0, 4'd3, R_M0);
         7'd8:   u = tk(OP_MUL, R_M1, 4'd4, K_PX);
         7'd9:   u = tk(OP_MUL, R_A, 4'd5, K_PY);
         7'd10:  u = rr(OP_ADD, R_M1, R_M1, R_A);
         7'd11:  u = tk(OP_MUL, R_A, 4'd6, K_PZ);
         7'd12:  u = rr(OP_ADD, R_M1, R_M1, R_A);
         7'd13:  u = tr(OP_ADD, R_M1, 4'd7, R_M1);
         7'd14:  u = tk(OP_MUL, R_M2, 4'd8, K_PX);
         7'd15:  u = tk(OP_MUL, R_A, 4'd9, K_PY);
         7'd16:  u = rr(OP_ADD, R_M2, R_M2, R_A);
         7'd17:  u = tk(OP_MUL, R_A, 4'd10, K_PZ);
         7'd18:  u = rr(OP_ADD, R_M2, R_M2, R_A);
         7'd19:  u = tr(OP_ADD, R_M2, 4'd11, R_M2);
         7'd20:  u = tk(OP_LDTW, R_DIST, W_TYPE, K_ZERO);
         7'd21:  u = tk(OP_ADD, R_BL, W_BLEND, K_ZERO);
         7'd22:  u = jp(OP_JTYPE, L_JT);
         7'd23:  u = jp(OP_JMP, L_SPH);
         7'd24:  u = jp(OP_JMP, L_BOX);
         7'd25:  u = jp(OP_JMP, L_PIPE);
         7'd26:  u = jp(OP_JMP, L_DON);
         7'd27:  u = rr(OP_SQ0, R_A, R_M0, R_M0);
         7'd28:  u = rr(OP_SQA, R_A, R_M1, R_M1);
         7'd29:  u = rr(OP_SQA, R_A, R_M2, R_M2);
         7'd30:  u = rr(OP_SQRT, R_A, R_A, R_A);
         7'd31:  u = rk(OP_SUB, R_OD, R_A, K_HALF);
         7'd32:  u = jp(OP_JMP, L_SCALE);
         7'd33:  u = rr(OP_ABS, R_A, R_M0, R_M0);
         7'd34:  u = rk(OP_SUB, R_A, R_A, K_HALF);
         7'd35:  u = rr(OP_ABS, R_B, R_M1, R_M1);
         7'd36:  u = rk(OP_SUB, R_B, R_B, K_HALF);
         7'd37:  u = rr(OP_ABS, R_C, R_M2, R_M2);
         7'd38:  u = rk(OP_SUB, R_C, R_C, K_HALF);
         7'd39:  u = rk(OP_MAX, R_D, R_A, K_ZERO);
         7'd40:  u = rr(OP_SQ0, R_D, R_D, R_D);
         7'd41:  u = rk(OP_MAX, R_D, R_B, K_ZERO);
         7'd42:  u = rr(OP_SQA, R_D, R_D, R_D);
         7'd43:  u = rk(OP_MAX, R_D, R_C, K_ZERO);
         7'd44:  u = rr(OP_SQA, R_D, R_D, R_D);
         7'd45:  u = rr(OP_SQRT, R_D, R_D, R_D);
         7'd46:  u = rk(OP_MIN, R_E, R_A, K_ZERO);
         7'd47:  u = rk(OP_MIN, R_F, R_B, K_ZERO);
         7'd48:  u = rr(OP_MAX, R_E, R_E, R_F);
         7'd49:  u = rk(OP_MIN, R_F, R_C, K_ZERO);
         7'd50:  u = rr(OP_MAX, R_E, R_E, R_F);
         7'd51:  u = rr(OP_ADD, R_OD, R_D, R_E);
         7'd52:  u = jp(OP_JMP, L_SCALE);
         7'd53:  u = rr(OP_SQ0, R_A, R_M0, R_M0);
         7'd54:  u = rr(OP_SQA, R_A, R_M2, R_M2);
         7'd55:  u = rr(OP_SQRT, R_A, R_A, R_A);
         7'd56:  u = rk(OP_SUB, R_A, R_A, K_HALF);
         7'd57:  u = rr(OP_ABS, R_B, R_M1, R_M1);
         7'd58:  u = rk(OP_SUB, R_B, R_B, K_ONE);
         7'd59:  u = rr(OP_MAX, R_OD, R_A, R_B);
         7'd60:  u = jp(OP_JMP, L_SCALE);
         7'd61:  u = rr(OP_SQ0, R_A, R_M0, R_M0);
         7'd62:  u = rr(OP_SQA, R_A, R_M2, R_M2);
         7'd63:  u = rr(OP_SQRT, R_A, R_A, R_A);
         7'd64:  u = rk(OP_SUB, R_A, R_A, K_ONE);
         7'd65:  u = rr(OP_SQ0, R_A, R_A, R_A);
         7'd66:  u = rr(OP_SQA, R_A, R_M1, R_M1);
         7'd67:  u = rr(OP_SQRT, R_OD, R_A, R_A);
         7'd68:  u = tr(OP_MUL, R_OD, W_SCALE, R_OD);
         7'd69:  u = jp(OP_JOP, L_JO);
         7'd70:  u = jp(OP_JMP, L_UR);
         7'd71:  u = jp(OP_JMP, L_UC);
         7'd72:  u = jp(OP_JMP, L_DR);
         7'd73:  u = jp(OP_JMP, L_DC);
         7'd74:  u = jp(OP_JMP, L_IR);
         7'd75:  u = jp(OP_JMP, L_IC);
         7'd76:  u = jp(OP_JMP, L_ZR);
         7'd77:  u = jp(OP_JMP, L_ZR);
         7'd78:  u = rr(OP_NEG, R_OD, R_OD, R_OD);
         7'd79:  u = jp(OP_JMP, L_IR);
         7'd80:  u = rr(OP_NEG, R_OD, R_OD, R_OD);
         7'd81:  u = jp(OP_JMP, L_IC);
         7'd82:  u = rk(OP_MOVB, R_DIST, R_DIST, K_ZERO);
         7'd83:  u = jp(OP_JMP, L_NEXT);
         7'd84:  u = rr(OP_SUB, R_A, R_BL, R_DIST);
         7'd85:  u = rk(OP_MAX, R_A, R_A, K_ZERO);
         7'd86:  u = rr(OP_SUB, R_B, R_BL, R_OD);
         7'd87:  u = rk(OP_MAX, R_B, R_B, K_ZERO);
         7'd88:  u = rr(OP_MIN, R_C, R_DIST, R_OD);
         7'd89:  u = rr(OP_MAX, R_C, R_BL, R_C);
         7'd90:  u = rr(OP_SQ0, R_A, R_A, R_A);
         7'd91:  u = rr(OP_SQA, R_B, R_B, R_B);
         7'd92:  u = rr(OP_SQRT, R_D, R_D, R_D);
         7'd93:  u = rr(OP_SUB, R_DIST, R_C, R_D);
         7'd94:  u = jp(OP_JMP, L_NEXT);
         7'd95:  u = rr(OP_SUB, R_A, R_DIST, R_BL);
         7'd96:  u = rr(OP_ADD, R_A, R_A, R_OD);
         7'd97:  u = rk(OP_MUL, R_A, R_A, K_RSQ2);
         7'd98:  u = rr(OP_MIN, R_B, R_DIST, R_OD);
         7'd99:  u = rr(OP_MIN, R_DIST, R_B, R_A);
         7'd100: u = jp(OP_JMP, L_NEXT);
         7'd101: u = rr(OP_ADD, R_A, R_BL, R_DIST);
         7'd102: u = rk(OP_MAX, R_A, R_A, K_ZERO);
         7'd103: u = rr(OP_ADD, R_B, R_BL, R_OD);
         7'd104: u = rk(OP_MAX, R_B, R_B, K_ZERO);
         7'd105: u = rr(OP_NEG, R_C, R_BL, R_BL);
         7'd106: u = rr(OP_MAX, R_D, R_DIST, R_OD);
         7'd107: u = rr(OP_MIN, R_C, R_C, R_D);
         7'd108: u = rr(OP_SQ0, R_A, R_A, R_A);
         7'd109: u = rr(OP_SQA, R_B, R_B, R_B);
         7'd110: u = rr(OP_SQRT, R_D, R_D, R_D);
         7'd111: u = rr(OP_ADD, R_DIST, R_C, R_D);
         7'd112: u = jp(OP_JMP, L_NEXT);
         7'd113: u = rr(OP_ADD, R_A, R_DIST, R_BL);
         7'd114: u = rr(OP_ADD, R_A, R_A, R_OD);
         7'd115: u = rk(OP_MUL, R_A, R_A, K_RSQ2);
         7'd116: u = rr(OP_MAX, R_B, R_DIST, R_OD);
         7'd117: u = rr(OP_MAX, R_DIST, R_B, R_A);
         7'd118: u = jp(OP_JMP, L_NEXT);
         7'd119: u = jp(OP_NXT, L_OBJ);
         default: u = rr(OP_OUT, R_DIST, R_DIST, R_DIST);
      endcase
      return u;
   endfunction

endpackage

[src/sdf_scene_distance_eval_core.sv]
// Signed-distance scene evaluator. Write requests (tuser 0) store one word of
// an object's table. A query request (tuser 1) starts from the ground
// distance and folds in the first min(object_count, 32) objects with a
// microcoded sequencer that drives one shared ALU, one 33x33 multiplier and a
// bit-serial square root. Each micro-operation has an operand-read state and
// an execute state; a multiply or square adds a state that takes the product,
// and a root waits in its own state until the square root unit is done.
// The block takes no request while a query is in progress.
module sdf_scene_distance_eval_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // object_index, word_index, word_value, point_x, point_y, point_z, zero pad
   input  logic [sdfe_pkg::REQ_W-1:0]   req_tdata,
   // kind
   input  logic [0:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // distance
   output logic [sdfe_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sdfe_pkg::CFG_W-1:0]   csr_data
);
   import sdfe_pkg::*;

   logic [31:0] tbl_mem [0:TBL_DEPTH-1];
   logic [31:0] rf_mem  [0:(1<<RF_AW)-1];

   state_type            state_ff, state_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [OBJ_CNT_W-1:0] obj_ff, obj_in;
   logic [CFG_W-1:0]     count_ff, count_in;
   logic [4:0]           tw_ff, tw_in;
   logic [63:0]          acc_ff, acc_in;
   logic signed [31:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;
   uins_type             ir_ff;
   logic [31:0]          ra_ff, rb_ff, tbl_rd_ff;

   uins_type             uins;
   logic [OBJ_W-1:0]     req_obj;
   logic [WORD_W-1:0]    req_word;
   logic signed [31:0]   req_value;
   logic                 req_kind;
   logic                 tbl_we;
   logic                 rf_we;
   logic [RF_AW-1:0]     rf_wa;
   logic signed [31:0]   rf_wd;
   logic signed [31:0]   x_val, y_val, alu_res;
   logic signed [32:0]   y_mag;
   logic                 mul_en;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   prod;
   logic                 sqrt_start, sqrt_done;
   logic [31:0]          sqrt_root;
   logic [OBJ_CNT_W-1:0] obj_lim;

   assign req_obj   = req_tdata[OBJ_W-1:0];
   assign req_word  = req_tdata[OBJ_W +: WORD_W];
   assign req_value = req_tdata[OBJ_W+WORD_W +: 32];
   assign req_kind  = req_tuser[0];
   assign uins      = rom_fetch(pc_ff);

   assign obj_lim = (count_ff > CFG_W'(MAX_OBJECTS)) ? OBJ_CNT_W'(MAX_OBJECTS)
                                                     : OBJ_CNT_W'(count_ff);

   always_comb begin
      x_val = ir_ff.xt ? tbl_rd_ff : ra_ff;
      unique case (ir_ff.yi)
         K_ZERO:  y_val = ir_ff.yc ? 32'sd0 : rb_ff;
         K_HALF:  y_val = ir_ff.yc ? Q_HALF : rb_ff;
         K_ONE:   y_val = ir_ff.yc ? Q_ONE : rb_ff;
         K_RSQ2:  y_val = ir_ff.yc ? Q_RSQRT2 : rb_ff;
         K_PX:    y_val = ir_ff.yc ? px_ff : rb_ff;
         K_PY:    y_val = ir_ff.yc ? py_ff : rb_ff;
         K_PZ:    y_val = ir_ff.yc ? pz_ff : rb_ff;
         default: y_val = rb_ff;
      endcase
   end

   assign y_mag = y_val[31] ? -{y_val[31], y_val} : {y_val[31], y_val};

   sdfe_alu u_alu (
      .op  (ir_ff.op),
      .x   (x_val),
      .y   (y_val),
      .res (alu_res)
   );

   sdfe_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   sdfe_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .n     (acc_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      obj_in       = obj_ff;
      tw_in        = tw_ff;
      acc_in       = acc_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      count_in     = csr_valid ? csr_data : count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      tbl_we       = 1'b0;
      rf_we        = 1'b0;
      rf_wa        = ir_ff.dst;
      rf_wd        = alu_res;
      mul_en       = 1'b0;
      mul_a        = {x_val[31], x_val};
      mul_b        = {y_val[31], y_val};
      sqrt_start   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == KIND_WRITE) begin
                  tbl_we = 1'b1;
               end else begin
                  px_in    = req_tdata[OBJ_W+WORD_W+32 +: 32];
                  py_in    = req_tdata[OBJ_W+WORD_W+64 +: 32];
                  pz_in    = req_tdata[OBJ_W+WORD_W+96 +: 32];
                  pc_in    = '0;
                  obj_in   = '0;
                  state_in = S_RD;
               end
            end
         end
         S_RD: state_in = S_EX;
         S_EX: begin
            state_in = S_RD;
            pc_in    = pc_ff + 7'd1;
            case (ir_ff.op) inside
               OP_MUL: begin
                  mul_en   = 1'b1;
                  state_in = S_MUL;
               end
               OP_SQ0, OP_SQA: begin
                  mul_en   = 1'b1;
                  mul_a    = y_mag;
                  mul_b    = y_mag;
                  state_in = S_SQ;
               end
               OP_SQRT: begin
                  sqrt_start = 1'b1;
                  state_in   = S_SQRT;
               end
               OP_LDTW:  tw_in = x_val[4:0];
               OP_CHK: begin
                  if (obj_ff >= obj_lim) pc_in = ir_ff.tgt;
               end
               OP_JMP:   pc_in = ir_ff.tgt;
               OP_JTYPE: pc_in = ir_ff.tgt + {5'd0, tw_ff[1:0]};
               OP_JOP:   pc_in = ir_ff.tgt + {4'd0, tw_ff[4:2]};
               OP_NXT: begin
                  obj_in = obj_ff + OBJ_CNT_W'(1);
                  pc_in  = ir_ff.tgt;
               end
               OP_OUT:   state_in = S_OUT;
               default:  rf_we = 1'b1;
            endcase
         end
         S_MUL: begin
            rf_we    = 1'b1;
            rf_wd    = qround(prod);
            state_in = S_RD;
         end
         S_SQ: begin
            acc_in   = ((ir_ff.op == OP_SQA) ? acc_ff : 64'd0) + 64'(prod[63:0]);
            state_in = S_RD;
         end
         S_SQRT: begin
            if (sqrt_done) begin
               rf_we    = 1'b1;
               rf_wd    = sqrt_root[31] ? Q_MAX : sqrt_root;
               state_in = S_RD;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ra_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[{req_obj, req_word}] <= req_value;
      if (state_ff == S_RD) begin
         ra_ff     <= rf_mem[uins.xi];
         rb_ff     <= rf_mem[uins.yi];
         tbl_rd_ff <= tbl_mem[{obj_ff[OBJ_W-1:0], uins.xi}];
         ir_ff     <= uins;
      end
      if (rf_we) rf_mem[rf_wa] <= rf_wd;
   end

   always_ff @(posedge clock) begin
      pc_ff       <= pc_in;
      obj_ff      <= obj_in;
      tw_ff       <= tw_in;
      acc_ff      <= acc_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   a_obj_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (obj_ff <= OBJ_CNT_W'(MAX_OBJECTS)))
      else $error("object counter past table");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (pc_ff <= L_DONE))
      else $error("sequencer left program");

   a_out_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("query finished without result");
endmodule

[src/sdfe_alu.sv]
module sdfe_alu (
   input  sdfe_pkg::op_type     op,
   input  logic signed [31:0]   x,
   input  logic signed [31:0]   y,
   output logic signed [31:0]   res
);
   import sdfe_pkg::*;

   logic signed [32:0] sx;
   logic signed [32:0] sy;

   assign sx = {x[31], x};
   assign sy = {y[31], y};

   always_comb begin
      unique case (op)
         OP_ADD:  res = sat_w(49'(sx + sy));
         OP_SUB:  res = sat_w(49'(sx - sy));
         OP_MAX:  res = (x > y) ? x : y;
         OP_MIN:  res = (x < y) ? x : y;
         OP_NEG:  res = sat_w(49'(-sy));
         OP_ABS:  res = y[31] ? sat_w(49'(-sy)) : y;
         OP_MOVB: res = y;
         default: res = '0;
      endcase
   end
endmodule

[src/sdfe_mul.sv]
module sdfe_mul (
   input  logic               clock,
   input  logic               en,
   input  logic signed [32:0] a,
   input  logic signed [32:0] b,
   output logic signed [65:0] prod
);
   logic signed [65:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) prod_ff <= a * b;
   end

   assign prod = prod_ff;
endmodule

[src/sdfe_sqrt.sv]
module sdfe_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] n,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] n_ff, n_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [34:0] rem_sh;
   logic [34:0] trial;

   assign rem_sh = {rem_ff[32:0], n_ff[63:62]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = n;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = {n_ff[61:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[30:0], 1'b0};
         end
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
